>>> hdl/gpm_pkg.sv
// shared types, codes and helpers for the glob pattern matcher
package gpm_pkg;

    localparam int IDX_W = 9;

    // token kinds
    localparam logic [1:0] K_BYTE = 2'd0;
    localparam logic [1:0] K_RST  = 2'd1;
    localparam logic [1:0] K_END  = 2'd2;

    // input commands
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_BYTE   = 2'd2;
    localparam logic [1:0] CMD_END    = 2'd3;

    // configuration register indexes
    localparam logic REG_FOLD = 1'b0;
    localparam logic REG_EQS  = 1'b1;

    // role of one pattern byte
    localparam logic [3:0] R_NONE   = 4'd0;
    localparam logic [3:0] R_STAR   = 4'd1;
    localparam logic [3:0] R_EQ     = 4'd2;
    localparam logic [3:0] R_ANY    = 4'd3;
    localparam logic [3:0] R_LIT    = 4'd4;
    localparam logic [3:0] R_ESC    = 4'd5;
    localparam logic [3:0] R_ESCLIT = 4'd6;
    localparam logic [3:0] R_COPEN  = 4'd7;
    localparam logic [3:0] R_CARET  = 4'd8;
    localparam logic [3:0] R_MEMBER = 4'd9;
    localparam logic [3:0] R_RLO    = 4'd10;
    localparam logic [3:0] R_RDASH  = 4'd11;
    localparam logic [3:0] R_RHI    = 4'd12;
    localparam logic [3:0] R_CLOSE  = 4'd13;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef struct packed {
        logic             vld;
        logic [1:0]       kind;
        logic             wr;
        logic             fix;
        logic [IDX_W-1:0] idx;
        logic [3:0]       role;
        logic [7:0]       dat;
        logic [IDX_W-1:0] len;
        logic             bad;
        logic             res;
        logic             nact;
        logic             pend;
        logic             hit;
        logic             inv;
        logic             ge;
    } t_tok;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        if (en && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

endpackage

>>> hdl/gpm_parser.sv
// pattern length, class parse state and entry token builder
module gpm_parser #(
    parameter int PATTERN_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [1:0]    i_cmd,
    input  logic [7:0]    i_byte,
    output gpm_pkg::t_tok o_tok
);
    import gpm_pkg::*;

    localparam logic [2:0] S_NORM   = 3'd0;
    localparam logic [2:0] S_ESC    = 3'd1;
    localparam logic [2:0] S_OPEN   = 3'd2;
    localparam logic [2:0] S_FIRST  = 3'd3;
    localparam logic [2:0] S_AFTER  = 3'd4;
    localparam logic [2:0] S_DASH   = 3'd5;
    localparam logic [2:0] S_MSTART = 3'd6;

    logic [IDX_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    logic [2:0]       r_st, n_st;
    logic [2:0]       app_st;
    logic [3:0]       role;
    logic             fix;
    logic             full;
    logic             in_class;

    assign full     = (r_len == IDX_W'(PATTERN_BYTES));
    assign in_class = (r_st != S_NORM) && (r_st != S_ESC);

    always_comb begin
        role   = R_LIT;
        fix    = 1'b0;
        app_st = r_st;
        unique case (r_st)
            S_NORM: begin
                app_st = S_NORM;
                if (i_byte == CH_STAR) begin
                    role = R_STAR;
                end else if (i_byte == CH_EQ) begin
                    role = R_EQ;
                end else if (i_byte == CH_QUES) begin
                    role = R_ANY;
                end else if (i_byte == CH_BSL) begin
                    role   = R_ESC;
                    app_st = S_ESC;
                end else if (i_byte == CH_LBRK) begin
                    role   = R_COPEN;
                    app_st = S_OPEN;
                end
            end
            S_ESC: begin
                role   = R_ESCLIT;
                app_st = S_NORM;
            end
            S_OPEN: begin
                if (i_byte == CH_CARET) begin
                    role   = R_CARET;
                    app_st = S_FIRST;
                end else begin
                    role   = R_MEMBER;
                    app_st = S_AFTER;
                end
            end
            S_FIRST: begin
                role   = R_MEMBER;
                app_st = S_AFTER;
            end
            S_AFTER: begin
                if (i_byte == CH_RBRK) begin
                    role   = R_CLOSE;
                    app_st = S_NORM;
                end else if (i_byte == CH_DASH) begin
                    role   = R_MEMBER;
                    app_st = S_DASH;
                end else begin
                    role   = R_MEMBER;
                    app_st = S_AFTER;
                end
            end
            S_DASH: begin
                if (i_byte == CH_RBRK) begin
                    role   = R_CLOSE;
                    app_st = S_NORM;
                end else begin
                    // two bytes back become a range start and its dash
                    role   = R_RHI;
                    fix    = 1'b1;
                    app_st = S_MSTART;
                end
            end
            S_MSTART: begin
                if (i_byte == CH_RBRK) begin
                    role   = R_CLOSE;
                    app_st = S_NORM;
                end else begin
                    role   = R_MEMBER;
                    app_st = S_AFTER;
                end
            end
            default: begin
                app_st = S_NORM;
            end
        endcase
    end

    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        n_st  = r_st;
        o_tok = '0;
        o_tok.vld  = i_acc;
        o_tok.dat  = i_byte;
        o_tok.role = role;
        o_tok.idx  = r_len;
        o_tok.len  = r_len;
        o_tok.bad  = r_ovf | in_class;
        o_tok.nact = 1'b1;
        unique case (i_cmd)
            CMD_CLEAR: begin
                o_tok.kind = K_RST;
                o_tok.len  = '0;
                n_len = '0;
                n_ovf = 1'b0;
                n_st  = S_NORM;
            end
            CMD_APPEND: begin
                o_tok.kind = K_RST;
                if (full) begin
                    n_ovf = 1'b1;
                end else begin
                    o_tok.wr  = 1'b1;
                    o_tok.fix = fix;
                    o_tok.len = r_len + 1'b1;
                    n_len = r_len + 1'b1;
                    n_st  = app_st;
                end
            end
            CMD_BYTE: begin
                o_tok.kind = K_BYTE;
                o_tok.nact = 1'b0;
            end
            CMD_END: begin
                o_tok.kind = K_END;
            end
            default: begin
                o_tok.kind = K_END;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
            r_st  <= S_NORM;
        end else if (i_acc) begin
            r_len <= n_len;
            r_ovf <= n_ovf;
            r_st  <= n_st;
        end
    end

endmodule

>>> hdl/gpm_cell.sv
// one pattern position: stored byte, role, active bit and token stage
module gpm_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_fold,
    input  logic          i_eqs,
    input  gpm_pkg::t_tok i_tok,
    output gpm_pkg::t_tok o_tok
);
    import gpm_pkg::*;

    localparam logic [IDX_W:0] P0 = (IDX_W+1)'(IDX);
    localparam logic [IDX_W:0] P1 = (IDX_W+1)'(IDX + 1);
    localparam logic [IDX_W:0] P2 = (IDX_W+1)'(IDX + 2);

    logic [3:0] r_role, n_role;
    logic [7:0] r_byte, n_byte;
    logic       r_act, n_act;
    t_tok       r_tok, n_tok;
    logic       wr_here;
    logic       live;
    logic       at_end;
    logic [3:0] rk;
    logic [7:0] x;
    logic [7:0] b;

    assign wr_here = i_tok.wr && ({1'b0, i_tok.idx} == P0);
    assign live    = {1'b0, i_tok.len} > P0;
    assign at_end  = {1'b0, i_tok.len} == P0;
    assign x       = fold(i_tok.dat, i_fold);
    assign b       = fold(n_byte, i_fold);

    always_comb begin
        n_byte = wr_here ? i_tok.dat : r_byte;
        n_role = r_role;
        if (wr_here) begin
            n_role = i_tok.role;
        end else if (i_tok.fix && ({1'b0, i_tok.idx} == P2)) begin
            n_role = R_RLO;
        end else if (i_tok.fix && ({1'b0, i_tok.idx} == P1)) begin
            n_role = R_RDASH;
        end
        rk = live ? n_role : R_NONE;
        if (rk == R_EQ) begin
            rk = i_eqs ? R_STAR : R_LIT;
        end
    end

    always_comb begin
        n_tok      = i_tok;
        n_tok.nact = 1'b0;
        n_act      = i_tok.nact;
        if (i_tok.kind == K_BYTE) begin
            unique case (rk)
                R_STAR: begin
                    n_act      = i_tok.nact | r_act;
                    n_tok.nact = i_tok.nact | r_act;
                end
                R_ANY:    n_tok.nact = r_act;
                R_LIT:    n_tok.nact = r_act && (b == x);
                R_ESC:    n_tok.pend = r_act;
                R_ESCLIT: n_tok.nact = i_tok.pend && (b == x);
                R_COPEN: begin
                    n_tok.pend = r_act;
                    n_tok.hit  = 1'b0;
                    n_tok.inv  = 1'b0;
                end
                R_CARET:  n_tok.inv = 1'b1;
                R_MEMBER: n_tok.hit = i_tok.hit | (b == x);
                R_RLO:    n_tok.ge  = (b <= x);
                R_RHI:    n_tok.hit = i_tok.hit | (i_tok.ge && (x <= b));
                R_CLOSE:  n_tok.nact = i_tok.pend & (i_tok.hit ^ i_tok.inv);
                default: begin
                end
            endcase
        end else begin
            // restart: start position plus closure over stars
            n_tok.nact = (rk == R_STAR) ? i_tok.nact : 1'b0;
            if (i_tok.kind == K_END && at_end) begin
                n_tok.res = r_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= (IDX == 0);
            r_tok <= '0;
        end else if (i_en) begin
            r_tok <= n_tok;
            if (i_tok.vld) begin
                r_act <= n_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_tok.vld) begin
            r_role <= n_role;
            r_byte <= n_byte;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> hdl/glob_pattern_matcher.sv
// top level: parser, chain of pattern cells and result register
//
//  channel  | dir | fields (low bit first)
//  s stream | in  | tdata: cmd[1:0], data_byte[9:2]
//  m stream | out | tdata: matched[0], bad_pattern[1]
//  cfg      | in  | idx 0 fold_case, idx 1 equals_is_star
//
// one item per cycle while the chain is not stalled; each item walks the chain
// of PATTERN_BYTES+1 cell registers and then the result register before
// o_m_tvalid rises for an end command.
// the chain stalls only while an end result waits at the tail behind a full
// output register. synchronous reset; no clearing pass.
module glob_pattern_matcher #(
    parameter int PATTERN_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // cmd[1:0], data_byte[9:2]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // matched[0], bad_pattern[1]
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data
);
    import gpm_pkg::*;

    localparam int NC = PATTERN_BYTES + 1;

    t_tok       chain [NC+1];
    logic       en;
    logic       acc;
    logic       r_fold;
    logic       r_eqs;
    logic       r_ovld;
    logic       r_match;
    logic       r_bad;
    t_tok       tail;

    assign tail       = chain[NC];
    assign en         = !(r_ovld && !i_m_tready && tail.vld && tail.kind == K_END);
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;

    gpm_parser #(.PATTERN_BYTES(PATTERN_BYTES)) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_cmd   (i_s_tdata[1:0]),
        .i_byte  (i_s_tdata[9:2]),
        .o_tok   (chain[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        gpm_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_fold  (r_fold),
            .i_eqs   (r_eqs),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= 1'b0;
            r_eqs  <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_FOLD) begin
                r_fold <= i_cfg_data;
            end else begin
                r_eqs <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en && tail.vld && tail.kind == K_END) begin
            r_ovld <= 1'b1;
        end else if (i_m_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && tail.vld && tail.kind == K_END) begin
            r_match <= tail.res & ~tail.bad;
            r_bad   <= tail.bad;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {6'b0, r_bad, r_match};

endmodule

>>> hdl/gpm_checker.sv
// port-level checks for the glob pattern matcher, bound to the top level
module gpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result item dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result item changed while stalled");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("match reported on a bad pattern");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[7:2] == 6'd0)
        else $error("padding bits set");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");
endmodule

bind glob_pattern_matcher gpm_checker u_gpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

>>> tb/tb_top.sv
// testbench for the glob pattern matcher: directed table, random patterns, nfa predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gpm_pkg::*;

    localparam int PB = 64;
    localparam int CYCLE_LIMIT = 400000;

    // element kinds of the predictor
    localparam int EK_STAR  = 0;
    localparam int EK_ANY   = 1;
    localparam int EK_LIT   = 2;
    localparam int EK_CLASS = 3;
    localparam int EK_DEAD  = 4;
    localparam int EK_BAD   = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // cmd[1:0], data_byte[9:2]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;   // matched[0], bad_pattern[1]
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic        i_cfg_data;

    glob_pattern_matcher #(.PATTERN_BYTES(PB)) u_top (.*);

    typedef struct packed {
        logic matched;
        logic bad;
    } t_verdict;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] dat;
        logic       chk;
        t_verdict   want;
    } t_row;

    // predictor state
    logic [7:0]  pat [PB];
    int          pat_len;
    logic        pat_ovf;
    logic [PB:0] live;
    logic        fold_en;
    logic        eq_star;

    t_verdict    verdict_q[$];
    t_verdict    typed_q[$];
    logic        typed_flag_q[$];
    int          errors;
    int          cycles;
    int          send_idle;
    int          recv_stall;
    int          results_seen;

    function automatic logic [7:0] fc(logic [7:0] c);
        if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic int mstep(int m);
        if (m + 2 < pat_len && pat[m+1] == CH_DASH && pat[m+2] != CH_RBRK) begin
            return m + 3;
        end
        return m + 1;
    endfunction

    // element that starts at position i
    task automatic elem_at(input int i, output int kind, output logic [7:0] lit,
                           output int lo, output int cls, output logic inv, output int nxt);
        int j;
        int m;
        logic [7:0] b;
        b = pat[i];
        kind = EK_LIT; lit = b; lo = 0; cls = 0; inv = 0; nxt = i + 1;
        if (b == CH_STAR || (b == CH_EQ && eq_star)) begin
            kind = EK_STAR;
        end else if (b == CH_QUES) begin
            kind = EK_ANY;
        end else if (b == CH_BSL) begin
            if (i + 1 < pat_len) begin
                lit = pat[i+1];
                nxt = i + 2;
            end else begin
                kind = EK_DEAD;
                nxt = pat_len;
            end
        end else if (b == CH_LBRK) begin
            j = i + 1;
            if (j < pat_len && pat[j] == CH_CARET) begin
                inv = 1;
                j++;
            end
            if (j >= pat_len) begin
                kind = EK_BAD;
                nxt = pat_len;
            end else begin
                m = mstep(j);
                while (m < pat_len && pat[m] != CH_RBRK) m = mstep(m);
                if (m >= pat_len) begin
                    kind = EK_BAD;
                    nxt = pat_len;
                end else begin
                    kind = EK_CLASS; lo = j; cls = m; nxt = m + 1;
                end
            end
        end
    endtask

    function automatic logic class_match(int lo, int cls, logic inv, logic [7:0] c);
        int m;
        int n;
        logic hit;
        logic [7:0] x;
        m = lo; hit = 0; x = fc(c);
        do begin
            n = mstep(m);
            if (n == m + 3) begin
                if (fc(pat[m]) <= x && x <= fc(pat[m+2])) hit = 1;
            end else if (fc(pat[m]) == x) begin
                hit = 1;
            end
            m = n;
        end while (m < cls);
        return hit != inv;
    endfunction

    task automatic star_closure(inout logic [PB:0] act);
        int i, k, lo, cl, nx;
        logic [7:0] lt;
        logic iv;
        i = 0;
        while (i < pat_len) begin
            elem_at(i, k, lt, lo, cl, iv, nx);
            if (k == EK_STAR && act[i]) act[nx] = 1;
            i = nx;
        end
    endtask

    task automatic restart_nfa();
        logic [PB:0] a;
        a = '0;
        a[0] = 1;
        star_closure(a);
        live = a;
    endtask

    task automatic predict_item(input logic [1:0] cmd, input logic [7:0] b);
        int i, k, lo, cl, nx;
        logic [7:0] lt;
        logic iv, bad;
        logic [PB:0] n;
        case (cmd)
            CMD_CLEAR: begin
                pat_len = 0;
                pat_ovf = 0;
                restart_nfa();
            end
            CMD_APPEND: begin
                if (pat_len < PB) begin
                    pat[pat_len] = b;
                    pat_len++;
                end else begin
                    pat_ovf = 1;
                end
                restart_nfa();
            end
            CMD_BYTE: begin
                n = '0;
                i = 0;
                while (i < pat_len) begin
                    elem_at(i, k, lt, lo, cl, iv, nx);
                    if (live[i]) begin
                        if (k == EK_STAR) n[i] = 1;
                        else if (k == EK_ANY) n[nx] = 1;
                        else if (k == EK_LIT && fc(lt) == fc(b)) n[nx] = 1;
                        else if (k == EK_CLASS && class_match(lo, cl, iv, b)) n[nx] = 1;
                    end
                    i = nx;
                end
                star_closure(n);
                live = n;
            end
            default: begin
                bad = pat_ovf;
                i = 0;
                while (i < pat_len) begin
                    elem_at(i, k, lt, lo, cl, iv, nx);
                    if (k == EK_BAD) bad = 1;
                    i = nx;
                end
                verdict_q.push_back('{matched: !bad && live[pat_len], bad: bad});
                restart_nfa();
            end
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // output checker
    always @(posedge i_clk) begin
        t_verdict exp_v;
        t_verdict got;
        if (i_rst_n) begin
            cycles <= cycles + 1;
            if (o_m_tvalid && i_m_tready) begin
                got = '{matched: o_m_tdata[0], bad: o_m_tdata[1]};
                if (verdict_q.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %b",
                             $time, o_m_tdata);
                    errors++;
                end else begin
                    exp_v = verdict_q.pop_front();
                    if (typed_flag_q.pop_front()) begin
                        if (typed_q[0] != exp_v) begin
                            $display("%0t table row disagrees: typed %b model %b",
                                     $time, typed_q[0], exp_v);
                            errors++;
                        end
                    end
                    if (typed_q.size() > 0) void'(typed_q.pop_front());
                    if (got.matched !== exp_v.matched) begin
                        $display("%0t matched: expected %b actual %b",
                                 $time, exp_v.matched, got.matched);
                        errors++;
                    end
                    if (got.bad !== exp_v.bad) begin
                        $display("%0t bad_pattern: expected %b actual %b",
                                 $time, exp_v.bad, got.bad);
                        errors++;
                    end
                    results_seen++;
                end
            end
            if (cycles > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // returns at the falling edge after the accept, with tvalid still high
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b,
                             input logic chk, input t_verdict want);
        while ($urandom_range(99) < send_idle) begin
            i_s_tvalid <= 0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= {6'd0, b, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_item(cmd, b);
        if (cmd == CMD_END) begin
            typed_flag_q.push_back(chk);
            typed_q.push_back(want);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        while (verdict_q.size() > 0) @(posedge i_clk);
        repeat (PB + 8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_EQS) eq_star = val;
        else fold_en = val;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 30) return 8'h61 + 8'($urandom_range(3));
        if (r < 40) return 8'h41 + 8'($urandom_range(3));
        if (r < 48) return CH_STAR;
        if (r < 54) return CH_QUES;
        if (r < 60) return CH_EQ;
        if (r < 64) return CH_BSL;
        if (r < 67) return CH_DASH;
        if (r < 70) return CH_RBRK;
        if (r < 72) return CH_CARET;
        if (r < 80) return 8'($urandom_range(255));
        return 8'h61 + 8'($urandom_range(3));
    endfunction

    t_row dir_tab[$];
    t_verdict nomatch = '{matched: 0, bad: 0};
    t_verdict yes = '{matched: 1, bad: 0};
    t_verdict badp = '{matched: 0, bad: 1};

    task automatic add_row(logic [1:0] c, logic [7:0] d, logic k = 0, t_verdict w = '0);
        dir_tab.push_back('{cmd: c, dat: d, chk: k, want: w});
    endtask

    initial begin
        int plen, slen, nitems, phase;
        logic [7:0] sub [$];
        i_rst_n = 0; i_s_tvalid = 0; i_s_tdata = 0; i_m_tready = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        errors = 0; cycles = 0; results_seen = 0;
        send_idle = 0; recv_stall = 0;
        pat_len = 0; pat_ovf = 0; fold_en = 0; eq_star = 0;
        restart_nfa();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // empty pattern matches the empty subject after reset
        add_row(CMD_END, 0, 1, yes);
        add_row(CMD_BYTE, 8'hFF, 1);
        add_row(CMD_END, 0, 1, nomatch);
        // unclosed class is bad
        add_row(CMD_APPEND, CH_LBRK);
        add_row(CMD_APPEND, CH_CARET);
        add_row(CMD_END, 0, 1, badp);
        // [^]-z] against byte 0 and an end-of-subject class
        add_row(CMD_APPEND, CH_RBRK);
        add_row(CMD_APPEND, CH_DASH);
        add_row(CMD_APPEND, 8'h7A);
        add_row(CMD_APPEND, CH_RBRK);
        add_row(CMD_BYTE, 8'h00);
        add_row(CMD_END, 0);
        add_row(CMD_END, 0, 1, nomatch);
        // trailing escape and trailing stars
        add_row(CMD_CLEAR, 0);
        add_row(CMD_APPEND, CH_STAR);
        add_row(CMD_APPEND, CH_STAR);
        add_row(CMD_END, 0, 1, yes);
        add_row(CMD_APPEND, CH_BSL);
        add_row(CMD_BYTE, 8'h5C);
        add_row(CMD_END, 0, 1, nomatch);
        add_row(CMD_CLEAR, 0);
        add_row(CMD_APPEND, CH_QUES);
        add_row(CMD_APPEND, CH_EQ);
        add_row(CMD_BYTE, 8'h3D);
        add_row(CMD_END, 0);
        foreach (dir_tab[r]) send_item(dir_tab[r].cmd, dir_tab[r].dat,
                                       dir_tab[r].chk, dir_tab[r].want);

        // overflow, with case folding and equals as star
        drain();
        write_reg(REG_FOLD, 1);
        write_reg(REG_EQS, 1);
        send_item(CMD_CLEAR, 0, 0, nomatch);
        for (int i = 0; i <= PB; i++) send_item(CMD_APPEND, CH_STAR, 0, nomatch);
        send_item(CMD_END, 0, 1, badp);
        send_item(CMD_CLEAR, 0, 0, nomatch);
        send_item(CMD_APPEND, 8'h41, 0, nomatch);
        send_item(CMD_APPEND, CH_EQ, 0, nomatch);
        send_item(CMD_BYTE, 8'h61, 0, nomatch);
        send_item(CMD_END, 0, 1, yes);

        nitems = 0;
        phase = 0;
        while (nitems < 1350) begin
            if (nitems >= phase * 180) begin
                drain();
                write_reg(REG_FOLD, phase[0]);
                write_reg(REG_EQS, phase[1]);
                case (phase % 4)
                    0: begin send_idle = 0; recv_stall = 0; end
                    1: begin send_idle = 50; recv_stall = 0; end
                    2: begin send_idle = 0; recv_stall = 50; end
                    default: begin send_idle = 20; recv_stall = 20; end
                endcase
                phase++;
            end
            send_item(CMD_CLEAR, 0, 0, nomatch);
            plen = ($urandom_range(19) == 0) ? $urandom_range(PB + 2) : $urandom_range(8);
            sub.delete();
            for (int i = 0; i < plen; i++) begin
                logic [7:0] c;
                c = pick_char();
                if (c == CH_RBRK && $urandom_range(1)) c = CH_LBRK;
                send_item(CMD_APPEND, c, 0, nomatch);
                // subject mostly tracks the pattern
                if (c != CH_STAR && c != CH_EQ && c != CH_BSL && $urandom_range(3) != 0)
                    sub.push_back(($urandom_range(3) == 0) ? (c ^ 8'h20) : c);
                else if ($urandom_range(1)) sub.push_back(pick_char());
            end
            nitems += plen + 1;
            for (int t = 0; t < 2; t++) begin
                slen = sub.size();
                for (int i = 0; i < slen; i++) send_item(CMD_BYTE,
                    ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : sub[i], 0, nomatch);
                send_item(CMD_END, 0, 0, nomatch);
                nitems += slen + 1;
            end
        end

        drain();
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> glob_pattern_matcher.f
hdl/gpm_pkg.sv
hdl/gpm_parser.sv
hdl/gpm_cell.sv
hdl/glob_pattern_matcher.sv
hdl/gpm_checker.sv
tb/tb_top.sv
